@@ rtl/mtg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_pkg
// constants, command type and word functions shared by the generator modules
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int WORD_W        = 32;
  localparam int PTR_W         = $clog2(STATE_WORDS);
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TOP_BIT      = 32'h80000000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(STATE_WORDS - 1);
  localparam logic [PTR_W-1:0] FAR_WRAP = PTR_W'(STATE_WORDS - MIDDLE_OFFSET);
  localparam logic [PTR_W-1:0] MID_OFS  = PTR_W'(MIDDLE_OFFSET);

  typedef logic [1:0] op_t;
  localparam op_t OP_SEED      = 2'd0;
  localparam op_t OP_DRAW      = 2'd1;
  localparam op_t OP_SEED_DRAW = 2'd2;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] seed;
  } cmd_t;

  function automatic logic [WORD_W-1:0] seed_step(input logic [WORD_W-1:0] prev,
                                                  input logic [PTR_W-1:0]  idx);
    logic [WORD_W-1:0] x;
    x = prev ^ (prev >> 30);
    seed_step = (SEED_MULT * x) + WORD_W'(idx);
  endfunction

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] upper,
                                                 input logic [WORD_W-1:0] lower);
    logic [WORD_W-1:0] m;
    m = (upper & TOP_BIT) | (lower & LOW_BITS);
    mix_word = (m >> 1) ^ (lower[0] ? TWIST_MATRIX : '0);
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    temper = y;
  endfunction

endpackage
`default_nettype wire

@@ rtl/mersenne_twister_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// 32-bit mt19937 generator with reseed and draw items on one input stream
// ----------------------------------------------------------------------------
// An item with in_tuser[0] low reseeds from in_tdata and gives no result; an
// item with in_tuser[0] high draws one tempered word on out_tdata. A reseed
// occupies the back end and writes one state word per cycle through the
// seeding multiplier. A draw reads the next and the middle state words from
// the state memory into registers, then twists, writes back and tempers into
// the output register once that register is free. A draw before any reseed
// first seeds from the default seed register, as a reseed does. Items queue
// in a short command fifo, so the input keeps accepting while the back end
// is busy until the fifo fills. The state memory needs no clearing after
// reset.
// ----------------------------------------------------------------------------
module mersenne_twister_generator #(
  parameter int QUEUE_DEPTH = mtg_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [0:0]                 in_tuser,   // mode
  input  wire logic [mtg_pkg::WORD_W-1:0] in_tdata,   // seed_value
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [mtg_pkg::WORD_W-1:0]      out_tdata,  // random_word
  input  wire logic                       cfg_we,
  input  wire logic [mtg_pkg::WORD_W-1:0] cfg_wdata   // default_seed
);

  logic          fq_valid;
  logic          fq_ready;
  mtg_pkg::cmd_t fq_cmd;
  logic          qb_valid;
  logic          qb_ready;
  mtg_pkg::cmd_t qb_cmd;

  mtg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_cmd     (fq_cmd)
  );

  mtg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_cmd   (qb_cmd)
  );

  mtg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_cmd      (qb_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

@@ rtl/mtg_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_front
// accepts input items, holds the default seed and the seeded flag, and turns
// each item into a seed, draw or seed-then-draw command
// ----------------------------------------------------------------------------
module mtg_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [0:0]                 in_tuser,
  input  wire logic [mtg_pkg::WORD_W-1:0] in_tdata,
  input  wire logic                       cfg_we,
  input  wire logic [mtg_pkg::WORD_W-1:0] cfg_wdata,
  output logic                            q_valid,
  input  wire logic                       q_ready,
  output mtg_pkg::cmd_t                   q_cmd
);

  logic                       seeded_r;
  logic [mtg_pkg::WORD_W-1:0] default_seed_r;
  logic                       accept;

  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;
  assign accept    = in_tvalid && q_ready;

  always_comb begin
    if (!in_tuser[0]) begin
      q_cmd.op   = mtg_pkg::OP_SEED;
      q_cmd.seed = in_tdata;
    end else if (!seeded_r) begin
      q_cmd.op   = mtg_pkg::OP_SEED_DRAW;
      q_cmd.seed = default_seed_r;
    end else begin
      q_cmd.op   = mtg_pkg::OP_DRAW;
      q_cmd.seed = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r       <= 1'b0;
      default_seed_r <= mtg_pkg::DEFAULT_SEED;
    end else begin
      if (accept) begin
        seeded_r <= 1'b1;
      end
      if (cfg_we) begin
        default_seed_r <= cfg_wdata;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/mtg_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_queue
// small command fifo between front and back
// ----------------------------------------------------------------------------
module mtg_queue #(
  parameter int DEPTH = mtg_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire mtg_pkg::cmd_t wr_cmd,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output mtg_pkg::cmd_t      rd_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  mtg_pkg::cmd_t   slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            push;
  logic            pop;

  assign wr_ready = (count_r != FULL);
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = slots_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/mtg_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_back
// state memory, seeding sequencer and on-the-fly twist with tempering into
// the output register
// ----------------------------------------------------------------------------
module mtg_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  input  wire mtg_pkg::cmd_t              q_cmd,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [mtg_pkg::WORD_W-1:0]      out_tdata
);

  localparam int W  = mtg_pkg::WORD_W;
  localparam int PW = mtg_pkg::PTR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_DRAW = 2'd2;

  logic [W-1:0]  words_r [mtg_pkg::STATE_WORDS];
  logic [1:0]    state_r;
  logic [1:0]    state_nxt;
  logic [PW-1:0] idx_r;
  logic [PW-1:0] ptr_r;
  logic          pend_r;
  logic [W-1:0]  prev_r;
  logic [W-1:0]  cur_r;
  logic [W-1:0]  rd_nxt_r;
  logic [W-1:0]  rd_far_r;
  logic          out_valid_r;
  logic [W-1:0]  out_data_r;

  logic          pop;
  logic          pop_seed;
  logic          out_free;
  logic          draw_done;
  logic          fill_last;
  logic [PW-1:0] nxt_addr;
  logic [PW-1:0] far_addr;
  logic [W-1:0]  fill_word;
  logic [W-1:0]  twist_word;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic          rd_en;

  assign q_ready    = (state_r == ST_IDLE) && !pend_r;
  assign pop        = q_ready && q_valid;
  assign pop_seed   = pop && (q_cmd.op != mtg_pkg::OP_DRAW);
  assign out_free   = !out_valid_r || out_tready;
  assign draw_done  = (state_r == ST_DRAW) && out_free;
  assign fill_last  = (idx_r == mtg_pkg::LAST_IDX);
  assign nxt_addr   = (ptr_r == mtg_pkg::LAST_IDX) ? '0 : ptr_r + PW'(1);
  assign far_addr   = (ptr_r < mtg_pkg::FAR_WRAP) ? ptr_r + mtg_pkg::MID_OFS
                                                  : ptr_r - mtg_pkg::FAR_WRAP;
  assign fill_word  = mtg_pkg::seed_step(prev_r, idx_r);
  assign twist_word = rd_far_r ^ mtg_pkg::mix_word(cur_r, rd_nxt_r);
  assign rd_en      = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = fill_word;
    case (state_r)
      ST_IDLE: begin
        wr_en   = pop_seed;
        wr_addr = '0;
        wr_data = q_cmd.seed;
      end
      ST_FILL: begin
        wr_en = 1'b1;
      end
      ST_DRAW: begin
        wr_en   = out_free;
        wr_addr = ptr_r;
        wr_data = twist_word;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pend_r) begin
          state_nxt = ST_DRAW;
        end else if (pop) begin
          state_nxt = pop_seed ? ST_FILL : ST_DRAW;
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state memory, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      words_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_nxt_r <= words_r[nxt_addr];
      rd_far_r <= words_r[far_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_seed) begin
      prev_r <= q_cmd.seed;
      cur_r  <= q_cmd.seed;
    end else if (state_r == ST_FILL) begin
      prev_r <= fill_word;
    end else if (draw_done) begin
      cur_r <= rd_nxt_r;
    end
    if (draw_done) begin
      out_data_r <= mtg_pkg::temper(twist_word);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop_seed) begin
        idx_r  <= PW'(1);
        pend_r <= (q_cmd.op == mtg_pkg::OP_SEED_DRAW);
      end else if (state_r == ST_FILL) begin
        idx_r <= idx_r + PW'(1);
        if (fill_last) begin
          ptr_r <= '0;
        end
      end else if (draw_done) begin
        ptr_r  <= nxt_addr;
        pend_r <= 1'b0;
      end
      if (draw_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/mtg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_checker
// port-level checks on the generator, attached by bind
// ----------------------------------------------------------------------------
module mtg_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic [0:0]                 in_tuser,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [mtg_pkg::WORD_W-1:0] out_tdata
);

  logic [7:0] draws_open_r;
  logic       draw_in;
  logic       item_out;

  assign draw_in  = in_tvalid && in_tready && in_tuser[0];
  assign item_out = out_tvalid && out_tready;

  // draws accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draws_open_r <= '0;
    end else begin
      draws_open_r <= draws_open_r + 8'(draw_in) - 8'(item_out);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> draws_open_r != 8'd0)
    else $error("result item without an open draw");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
